// ===== sv/bine_pkg.sv =====
// Package for the B+tree internal node engine: types, codes and defaults.
// No dependencies; every other file imports it.
package bine_pkg;

    localparam int NODE_CAPACITY_DEF = 63;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SPLIT  = 2'd2,
        CMD_INIT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_PROMOTE = 2'd1,
        KIND_UPPER   = 2'd2,
        KIND_RSVD    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST,
        ST_SHIFT,
        ST_SHDRAIN,
        ST_WNEW,
        ST_EREAD,
        ST_EOUT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] child;
    } t_cell;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
        logic [31:0] child_page;
        logic [31:0] left_child;
    } t_in_req;

    typedef struct packed {
        t_kind       out_kind;
        logic [31:0] out_key;
        logic [31:0] out_child;
        logic        status;
        logic [5:0]  count_after;
        logic        last;
    } t_out_res;

endpackage

// ===== sv/bine_if.sv =====
// Valid/ready channel interfaces for command requests and result requests.
// Depends on bine_pkg for the payload types.
interface bine_in_if import bine_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bine_out_if import bine_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/btree_internal_node_engine.sv =====
// Top level of the B+tree internal node engine: command sequencer and result register.
// Depends on bine_pkg, bine_if and bine_cell_mem.
//
//  channel | dir | payload                                          | side
//  i_req   | in  | cmd, key, child_page, left_child                 | sink
//  o_res   | out | out_kind, out_key, out_child, status, count_after, last | source
//
// One command at a time. Scan reads one cell a cycle from the cell store. Insert: scan
// to the insert point, then one shift per cell above it, then a write of the new pair.
// Split: scan, a cell read and an output per emitted request, then shifts of the lower
// half. Reset clears state, count, leftmost child and valid flags, not the cell store.
// Result stalls hold the sequencer; a finished result waits in the output register.
module btree_internal_node_engine
    import bine_pkg::*;
#(
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bine_in_if.sink     i_req,
    bine_out_if.source  o_res
);
    localparam int AW = $clog2(NODE_CAPACITY);
    localparam int CW = $clog2(NODE_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(NODE_CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [31:0] r_key, r_child, r_lm, r_prev_child, r_res_child;
    logic        r_res_stat;
    logic [CW-1:0] r_total, r_newtot, r_idx, r_cidx, r_pos, r_m, r_j, r_wa;
    logic          r_dv, r_wv;
    logic          r_ov;
    t_out_res      r_out;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_cell         wdata, rdata;
    logic          out_free, accept, hit, scan_done, em_last;
    logic [CW:0]   total1;
    logic [CW-1:0] mid;
    t_cell         em_cell;

    bine_cell_mem #(.DEPTH(NODE_CAPACITY)) u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign total1   = {1'b0, r_total} + {{CW{1'b0}}, 1'b1};
    assign mid      = total1[CW:1];
    assign out_free = !r_ov || o_res.ready;
    assign accept   = i_req.valid && i_req.ready;
    // split places the pair before equal keys, the others after them
    assign hit      = (r_cmd == CMD_SPLIT) ? !(rdata.key < r_key) : (r_key < rdata.key);
    assign scan_done = r_dv && (hit || (r_cidx == r_total - ONE));
    assign em_last  = (r_m == r_total);
    assign em_cell  = (r_m == r_pos) ? t_cell'{key: r_key, child: r_child} : rdata;

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.data.cmd == CMD_INIT) begin
                        n_state = ST_WNEW;
                    end else if (i_req.data.cmd == CMD_INSERT && r_total >= CAP) begin
                        n_state = ST_RESP;
                    end else if (r_total == '0) begin
                        n_state = ST_POST;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) n_state = ST_POST;
            end
            ST_POST: begin
                unique case (r_cmd)
                    CMD_LOOKUP: n_state = ST_RESP;
                    CMD_INSERT: n_state = (r_pos < r_total) ? ST_SHIFT : ST_WNEW;
                    CMD_SPLIT:  n_state = ST_EREAD;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_SHIFT: begin
                if (r_j == r_pos) n_state = ST_SHDRAIN;
            end
            ST_SHDRAIN: n_state = ST_WNEW;
            ST_WNEW:    n_state = (r_cmd == CMD_SPLIT) ? ST_IDLE : ST_RESP;
            ST_EREAD:   n_state = ST_EOUT;
            ST_EOUT: begin
                if (out_free) begin
                    if (!em_last) begin
                        n_state = ST_EREAD;
                    end else if (mid != '0 && r_pos < mid - ONE) begin
                        n_state = ST_SHIFT;
                    end else if (r_pos == mid - ONE) begin
                        n_state = ST_WNEW;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory control and handshake
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        we    = 1'b0;
        waddr = r_wa[AW-1:0];
        wdata = rdata;
        raddr = r_idx[AW-1:0];
        unique case (r_state)
            ST_SHIFT, ST_SHDRAIN: begin
                we    = r_wv;
                raddr = r_j[AW-1:0];
            end
            ST_WNEW: begin
                we    = 1'b1;
                waddr = r_pos[AW-1:0];
                wdata = t_cell'{key: r_key, child: r_child};
            end
            ST_EREAD, ST_EOUT: begin
                raddr = (r_m < r_pos) ? r_m[AW-1:0] : AW'(r_m - ONE);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_lm    <= '0;
            r_ov    <= 1'b0;
            r_wv    <= 1'b0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wv    <= 1'b0;
            if (r_ov && o_res.ready) r_ov <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd        <= i_req.data.cmd;
                        r_key        <= i_req.data.key;
                        r_child      <= i_req.data.child_page;
                        r_idx        <= '0;
                        r_dv         <= 1'b0;
                        r_prev_child <= r_lm;
                        r_pos        <= '0;
                        r_res_child  <= '0;
                        r_res_stat   <= 1'b0;
                        if (i_req.data.cmd == CMD_INIT) begin
                            r_lm     <= i_req.data.left_child;
                            r_newtot <= ONE;
                        end else if (i_req.data.cmd == CMD_INSERT && r_total >= CAP) begin
                            r_res_stat <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    r_idx  <= r_idx + ONE;
                    r_dv   <= (r_idx < r_total);
                    r_cidx <= r_idx;
                    if (r_dv) begin
                        if (hit) begin
                            r_pos <= r_cidx;
                        end else begin
                            r_prev_child <= rdata.child;
                            r_pos        <= r_total;
                        end
                    end
                end
                ST_POST: begin
                    r_res_child <= (r_cmd == CMD_LOOKUP && r_pos != '0) ? r_prev_child :
                                   (r_cmd == CMD_LOOKUP) ? r_lm : 32'd0;
                    r_newtot    <= (r_cmd == CMD_SPLIT) ? mid : r_total + ONE;
                    r_j         <= r_total - ONE;
                    r_m         <= mid;
                end
                ST_SHIFT: begin
                    r_wv <= 1'b1;
                    r_wa <= r_j + ONE;
                    r_j  <= r_j - ONE;
                end
                ST_WNEW: r_total <= r_newtot;
                ST_EOUT: begin
                    if (out_free) begin
                        r_ov                <= 1'b1;
                        r_out.out_kind      <= (r_m == mid) ? KIND_PROMOTE : KIND_UPPER;
                        r_out.out_key       <= em_cell.key;
                        r_out.out_child     <= em_cell.child;
                        r_out.status        <= 1'b0;
                        r_out.count_after   <= 6'(mid);
                        r_out.last          <= em_last;
                        r_m                 <= r_m + ONE;
                        r_j                 <= mid - ONE - ONE;
                        if (em_last && !(r_pos < mid)) r_total <= mid;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_ov              <= 1'b1;
                        r_out.out_kind    <= KIND_ACK;
                        r_out.out_key     <= '0;
                        r_out.out_child   <= r_res_child;
                        r_out.status      <= r_res_stat;
                        r_out.count_after <= 6'(r_total);
                        r_out.last        <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== sv/bine_cell_mem.sv =====
// Cell store: one write port, one read port, registered read data.
// Depends on bine_pkg for the cell type.
module bine_cell_mem
    import bine_pkg::*;
#(
    parameter int DEPTH = NODE_CAPACITY_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_cell         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_cell         o_rdata
);
    t_cell mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sim/btree_internal_node_engine_tb.sv =====
// Self-checking testbench for the B+tree internal node engine.
// Depends on bine_pkg, bine_if and btree_internal_node_engine; keeps its own node copy.
module btree_internal_node_engine_tb;
    import bine_pkg::*;

    localparam int CAP = NODE_CAPACITY_DEF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bine_in_if  req_if ();
    bine_out_if res_if ();

    btree_internal_node_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #5 i_clk = ~i_clk;

    // shadow node
    logic [31:0] node_keys [CAP];
    logic [31:0] node_kids [CAP];
    int unsigned node_count;
    logic [31:0] node_left;

    t_in_req  pending_cmds [$];
    t_out_res awaited_res [$];
    int       err_count = 0;
    bit       stim_done = 1'b0;
    bit       calm = 1'b0;   // no idling in the final stretch
    bit       req_fired = 1'b0;
    int       src_gap = 0;
    int       snk_gap = 0;

    function automatic void queue_cmd(t_in_req c);
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic void await_res(t_out_res r);
        awaited_res = {awaited_res, r};
    endfunction

    function automatic t_out_res make_res(t_kind k, logic [31:0] ky, logic [31:0] ch,
                                          logic st, int unsigned cnt, logic lst);
        t_out_res r;
        r.out_kind = k;
        r.out_key = ky;
        r.out_child = ch;
        r.status = st;
        r.count_after = cnt[5:0];
        r.last = lst;
        return r;
    endfunction

    // apply one command to the shadow node and queue the results it causes
    task automatic apply_node_cmd(t_in_req c);
        logic [31:0] mk [CAP+1];
        logic [31:0] mc [CAP+1];
        int unsigned pos, total, mid, upper, n;
        n = node_count;
        pos = 0;
        case (c.cmd)
            CMD_LOOKUP: begin
                while (pos < n && node_keys[pos] <= c.key) pos++;
                await_res(make_res(KIND_ACK, '0,
                    pos == 0 ? node_left : node_kids[pos-1], 1'b0, n, 1'b1));
            end
            CMD_INSERT: begin
                if (n >= CAP) begin
                    await_res(make_res(KIND_ACK, '0, '0, 1'b1, n, 1'b1));
                end else begin
                    while (pos < n && node_keys[pos] <= c.key) pos++;
                    for (int i = n; i > pos; i--) begin
                        node_keys[i] = node_keys[i-1];
                        node_kids[i] = node_kids[i-1];
                    end
                    node_keys[pos] = c.key;
                    node_kids[pos] = c.child_page;
                    node_count = n + 1;
                    await_res(make_res(KIND_ACK, '0, '0, 1'b0, n + 1, 1'b1));
                end
            end
            CMD_SPLIT: begin
                total = n + 1;
                mid = total / 2;
                upper = total - mid - 1;
                while (pos < n && node_keys[pos] < c.key) pos++;
                for (int i = 0; i < pos; i++) begin
                    mk[i] = node_keys[i];
                    mc[i] = node_kids[i];
                end
                mk[pos] = c.key;
                mc[pos] = c.child_page;
                for (int i = pos; i < n; i++) begin
                    mk[i+1] = node_keys[i];
                    mc[i+1] = node_kids[i];
                end
                for (int i = 0; i < mid; i++) begin
                    node_keys[i] = mk[i];
                    node_kids[i] = mc[i];
                end
                node_count = mid;
                await_res(make_res(KIND_PROMOTE, mk[mid], mc[mid], 1'b0, mid,
                                   upper == 0));
                for (int i = 0; i < upper; i++)
                    await_res(make_res(KIND_UPPER, mk[mid+1+i], mc[mid+1+i],
                                       1'b0, mid, i + 1 == upper));
            end
            default: begin
                node_count = 1;
                node_left = c.left_child;
                node_keys[0] = c.key;
                node_kids[0] = c.child_page;
                await_res(make_res(KIND_ACK, '0, '0, 1'b0, 1, 1'b1));
            end
        endcase
    endtask

    // remembers whether the last rising edge took the request
    always @(posedge i_clk) begin
        req_fired <= req_if.valid && req_if.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end else if (!req_if.valid || req_fired) begin
            if (src_gap > 0) begin
                src_gap--;
                req_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 10);
                req_if.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                req_if.valid <= 1'b1;
                req_if.data <= pending_cmds.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // ready with random stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            res_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            snk_gap = $urandom_range(1, 10);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                apply_node_cmd(req_if.data);
            if (res_if.valid && res_if.ready) begin
                if (awaited_res.size() == 0) begin
                    $error("unexpected result request %p", res_if.data);
                    err_count++;
                end else begin
                    t_out_res e;
                    e = awaited_res.pop_front();
                    if (res_if.data.out_kind !== e.out_kind) begin
                        $error("out_kind exp %0d got %0d", e.out_kind, res_if.data.out_kind);
                        err_count++;
                    end
                    if (res_if.data.out_key !== e.out_key) begin
                        $error("out_key exp %0h got %0h", e.out_key, res_if.data.out_key);
                        err_count++;
                    end
                    if (res_if.data.out_child !== e.out_child) begin
                        $error("out_child exp %0h got %0h", e.out_child,
                               res_if.data.out_child);
                        err_count++;
                    end
                    if (res_if.data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, res_if.data.status);
                        err_count++;
                    end
                    if (res_if.data.count_after !== e.count_after) begin
                        $error("count_after exp %0d got %0d", e.count_after,
                               res_if.data.count_after);
                        err_count++;
                    end
                    if (res_if.data.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, res_if.data.last);
                        err_count++;
                    end
                end
            end
        end
    end

    function automatic t_in_req mk_cmd(t_cmd c, logic [31:0] k, logic [31:0] ch,
                                       logic [31:0] lc);
        t_in_req r;
        r.cmd = c;
        r.key = k;
        r.child_page = ch;
        r.left_child = lc;
        return r;
    endfunction

    function automatic logic [31:0] rnd_key(int unsigned span);
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 2);
            1: return $urandom_range(0, 2);
            2: return $urandom();
            default: return $urandom_range(0, span);
        endcase
    endfunction

    initial begin
        int unsigned span, pick;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        for (int i = 0; i < CAP; i++) begin
            node_keys[i] = '0;
            node_kids[i] = '0;
        end
        node_count = 0;
        node_left = '0;

        // directed: empty node cases, extremes, full node refusal, splits
        queue_cmd(mk_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, '1, '1));
        queue_cmd(mk_cmd(CMD_SPLIT, 32'h0000_0005, 32'hAAAA_5555, '0));
        queue_cmd(mk_cmd(CMD_INIT, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        queue_cmd(mk_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, '0, '0));
        queue_cmd(mk_cmd(CMD_LOOKUP, 32'h8000_0000, '0, '0));
        queue_cmd(mk_cmd(CMD_INSERT, 32'h8000_0000, 32'h1111_1111, '0));
        queue_cmd(mk_cmd(CMD_INSERT, 32'h0, 32'h0, '0));
        queue_cmd(mk_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h5555_AAAA, '0));
        queue_cmd(mk_cmd(CMD_LOOKUP, 32'h8000_0000, '0, '0));
        queue_cmd(mk_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0));
        queue_cmd(mk_cmd(CMD_SPLIT, 32'h8000_0000, 32'h2222_2222, '0));
        queue_cmd(mk_cmd(CMD_INIT, 32'h0, 32'h0, 32'h0));
        // fill to capacity, then one refused insert, a lookup and a full split
        for (int i = 0; i < CAP - 1; i++)
            queue_cmd(mk_cmd(CMD_INSERT, i * 3, $urandom(), '0));
        queue_cmd(mk_cmd(CMD_INSERT, 32'h10, 32'h3, '0));
        queue_cmd(mk_cmd(CMD_LOOKUP, 32'h0, '0, '0));
        queue_cmd(mk_cmd(CMD_SPLIT, 32'h30, 32'hFFFF_FFFF, '0));

        // random: half inserts to grow the node, splits to shrink it, lookups and inits
        for (int i = 0; i < 393; i++) begin
            if (i == 343) begin
                wait (pending_cmds.size() == 0);
                calm = 1'b1;
            end
            span = ($urandom_range(0, 1) != 0) ? 64 : 32'hFFFF_FFFF;
            pick = $urandom_range(0, 19);
            if (pick < 6)
                queue_cmd(mk_cmd(CMD_LOOKUP, rnd_key(span), $urandom(), $urandom()));
            else if (pick < 16)
                queue_cmd(mk_cmd(CMD_INSERT, rnd_key(span), $urandom(), $urandom()));
            else if (pick < 19)
                queue_cmd(mk_cmd(CMD_SPLIT, rnd_key(span), $urandom(), $urandom()));
            else
                queue_cmd(mk_cmd(CMD_INIT, rnd_key(span), $urandom(), $urandom()));
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && pending_cmds.size() == 0);
        @(posedge i_clk);
        while (req_if.valid || awaited_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_count == 0 && !res_if.valid)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule
